### design/esh_pkg.sv
// Shared constants, types and command codes of the error statistics histogram.
package esh_pkg;

    localparam int NUM_BUCKETS = 150;
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 20;
    localparam int COUNT_BITS  = 32;

    localparam int MAG_BITS    = SAMPLE_BITS + 1;
    localparam int SQ_BITS     = 2 * MAG_BITS;
    localparam int SCALE_BITS  = 16;
    localparam int SCALED_BITS = MAG_BITS + SCALE_BITS;
    localparam int IDX_BITS    = $clog2(NUM_BUCKETS);
    localparam int HTOT_BITS   = COUNT_BITS + $clog2(NUM_BUCKETS);
    localparam int QUANT_BITS  = 17;
    localparam int QUANT_SHIFT = 16;
    localparam int QCMP_BITS   = HTOT_BITS + QUANT_BITS;

    localparam int SUM_BITS    = 64;
    localparam int SEEN_BITS   = 40;
    localparam int MAXERR_BITS = 24;
    localparam int SEL_BITS    = 8;
    localparam int QB_BITS     = 8;
    localparam int BC_BITS     = 32;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(5000);
    localparam logic [QUANT_BITS-1:0] QUANT_ONE   = QUANT_BITS'(65536);
    localparam logic [IDX_BITS-1:0]   LAST_IDX    = IDX_BITS'(NUM_BUCKETS - 1);

    typedef enum logic [1:0] {
        CMD_SAMPLE   = 2'd0,
        CMD_QUANTILE = 2'd1,
        CMD_READ     = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    // error datapath results handed to the control FSM
    typedef struct packed {
        logic [MAG_BITS-1:0] mag;
        logic [SQ_BITS-1:0]  sq;
        logic [IDX_BITS-1:0] idx;
    } t_calc;

endpackage

### design/esh_stream_if.sv
// Valid/ready stream interfaces for the command and result channels.
interface esh_in_if;
    import esh_pkg::*;

    logic                          valid;
    logic                          ready;
    t_cmd                          cmd;
    logic signed [SAMPLE_BITS-1:0] original_sample;
    logic signed [SAMPLE_BITS-1:0] restored_sample;
    logic [QUANT_BITS-1:0]         quantile_fraction;
    logic [SEL_BITS-1:0]           bucket_select;

    modport source (
        output valid, cmd, original_sample, restored_sample, quantile_fraction,
               bucket_select,
        input  ready
    );
    modport sink (
        input  valid, cmd, original_sample, restored_sample, quantile_fraction,
               bucket_select,
        output ready
    );
endinterface

interface esh_out_if;
    import esh_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SUM_BITS-1:0]    total_sq_error;
    logic [SEEN_BITS-1:0]   sample_count;
    logic [MAXERR_BITS-1:0] max_abs_error;
    logic [QB_BITS-1:0]     quantile_bucket;
    logic [BC_BITS-1:0]     bucket_count;

    modport source (
        output valid, total_sq_error, sample_count, max_abs_error, quantile_bucket,
               bucket_count,
        input  ready
    );
    modport sink (
        input  valid, total_sq_error, sample_count, max_abs_error, quantile_bucket,
               bucket_count,
        output ready
    );
endinterface

### design/esh_count_ram.sv
// Simple dual-port RAM with registered read, holds the bucket counts.
module esh_count_ram #(
    parameter int DEPTH = 150,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/esh_err_calc.sv
// Error datapath: magnitude of the difference, its square and the bucket index.
module esh_err_calc (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  logic signed [esh_pkg::SAMPLE_BITS-1:0] i_orig,
    input  logic signed [esh_pkg::SAMPLE_BITS-1:0] i_rest,
    input  logic [esh_pkg::SCALE_BITS-1:0]         i_scale,
    output esh_pkg::t_calc                         o_calc
);
    import esh_pkg::*;

    logic signed [MAG_BITS-1:0] w_diff;
    logic [MAG_BITS-1:0]        w_mag;
    logic [MAG_BITS-1:0]        r_mag;
    logic [SQ_BITS-1:0]         r_sq;
    logic [SCALED_BITS-1:0]     r_scaled;
    logic [SCALED_BITS-1:0]     w_shifted;

    assign w_diff = MAG_BITS'(i_orig) - MAG_BITS'(i_rest);
    assign w_mag  = w_diff[MAG_BITS-1] ? MAG_BITS'(-w_diff) : MAG_BITS'(w_diff);

    // stage 1: hold the magnitude of the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mag <= w_mag;
        end
    end

    // stage 2: both products
    always_ff @(posedge i_clk) begin
        r_sq     <= SQ_BITS'(r_mag) * SQ_BITS'(r_mag);
        r_scaled <= SCALED_BITS'(r_mag) * SCALED_BITS'(i_scale);
    end

    assign w_shifted = r_scaled >> FRAC_BITS;

    always_comb begin
        o_calc.mag = r_mag;
        o_calc.sq  = r_sq;
        // clamp to the last bucket
        if (w_shifted > SCALED_BITS'(NUM_BUCKETS - 1)) begin
            o_calc.idx = LAST_IDX;
        end else begin
            o_calc.idx = IDX_BITS'(w_shifted);
        end
    end
endmodule

### design/error_stats_histogram.sv
// Top level: command FSM, running statistics and bucket RAM read-modify-write.
//
//  channel   | dir | handshake          | beat
//  ----------+-----+--------------------+------------------------------------------
//  i_item    | in  | valid/ready        | cmd, samples, quantile fraction, bucket
//  o_result  | out | valid/ready        | sum, count, max error, quantile, bucket
//  i_cfg_*   | in  | write enable only  | bucket_scale, 16 bits
//
// One command is in flight at a time; the bucket RAM port sets the pace.
// Sample pair: two error datapath stages, RAM read, write-back, result.
// Read bucket: RAM read, then check, then result. Clear: straight to the result. Quantile:
// threshold multiply, then a walk over at most NUM_BUCKETS buckets, one RAM read per cycle.
// Reset and clear take effect at once through per-bucket valid flags.
// A stalled result waits in the output register and holds the FSM at its last step.
module error_stats_histogram (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [esh_pkg::SCALE_BITS-1:0] i_cfg_wdata,
    esh_in_if.sink                         i_item,
    esh_out_if.source                      o_result
);
    import esh_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_RMW,
        ST_QMUL,
        ST_QCHK,
        ST_RD,
        ST_RDCHK,
        ST_DONE
    } t_state;

    t_state                  r_state;
    logic [SCALE_BITS-1:0]   r_scale;
    logic [QUANT_BITS-1:0]   r_frac;
    logic [SEL_BITS-1:0]     r_sel;
    logic [SUM_BITS-1:0]     r_sum;
    logic [SEEN_BITS-1:0]    r_seen;
    logic [MAG_BITS-1:0]     r_largest;
    logic [HTOT_BITS-1:0]    r_htot;
    logic [NUM_BUCKETS-1:0]  r_valid;
    logic [IDX_BITS-1:0]     r_idx;
    logic [IDX_BITS-1:0]     r_qidx;
    logic [HTOT_BITS-1:0]    r_run;
    logic [QCMP_BITS-1:0]    r_thresh;
    logic [QB_BITS-1:0]      r_qb;
    logic [BC_BITS-1:0]      r_bc;
    logic                    r_out_valid;
    logic [SUM_BITS-1:0]     r_out_sum;
    logic [SEEN_BITS-1:0]    r_out_seen;
    logic [MAXERR_BITS-1:0]  r_out_max;
    logic [QB_BITS-1:0]      r_out_qb;
    logic [BC_BITS-1:0]      r_out_bc;

    logic                    w_accept;
    t_calc                   w_calc;
    logic                    w_ram_we;
    logic [IDX_BITS-1:0]     w_raddr;
    logic [COUNT_BITS-1:0]   w_rdata;
    logic [IDX_BITS-1:0]     w_cur_addr;
    logic                    w_cur_valid;
    logic [COUNT_BITS-1:0]   w_cnt;
    logic                    w_sel_ok;
    logic [SUM_BITS:0]       w_sum_add;
    logic                    w_sq_big;
    logic [SUM_BITS-1:0]     n_sum;
    logic [HTOT_BITS-1:0]    n_run;
    logic                    w_hit;
    logic [QUANT_BITS-1:0]   w_frac_clamp;
    logic                    w_out_free;

    assign w_accept     = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == ST_IDLE);
    assign w_out_free   = !r_out_valid || o_result.ready;

    esh_err_calc u_calc (
        .i_clk   (i_clk),
        .i_load  (w_accept),
        .i_orig  (i_item.original_sample),
        .i_rest  (i_item.restored_sample),
        .i_scale (r_scale),
        .o_calc  (w_calc)
    );

    // current bucket seen by the RAM data; a bucket not written since clear reads zero
    always_comb begin
        case (r_state)
            ST_RMW:   w_cur_addr = r_idx;
            ST_QCHK:  w_cur_addr = r_qidx;
            default:  w_cur_addr = IDX_BITS'(r_sel);
        endcase
    end

    assign w_sel_ok    = 32'(r_sel) < NUM_BUCKETS;
    assign w_cur_valid = r_valid[w_cur_addr];
    assign w_cnt       = w_cur_valid ? w_rdata : '0;

    always_comb begin
        case (r_state)
            ST_ADDR:  w_raddr = w_calc.idx;
            ST_QCHK:  w_raddr = (r_qidx == LAST_IDX) ? r_qidx : r_qidx + 1'b1;
            ST_RD:    w_raddr = IDX_BITS'(r_sel);
            default:  w_raddr = '0;
        endcase
    end

    assign w_ram_we = (r_state == ST_RMW) && (w_cnt != '1);

    esh_count_ram #(
        .DEPTH (NUM_BUCKETS),
        .WIDTH (COUNT_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (w_cnt + 1'b1),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // saturating sum of squares
    assign w_sq_big  = (w_calc.mag >> 32) != '0;
    assign w_sum_add = {1'b0, r_sum} + {1'b0, SUM_BITS'(w_calc.sq)};
    assign n_sum     = (w_sq_big || w_sum_add[SUM_BITS]) ? '1 : w_sum_add[SUM_BITS-1:0];

    // quantile walk: stop at the first bucket where run * one >= total * fraction, else at the last
    assign n_run = r_run + HTOT_BITS'(w_cnt);
    assign w_hit = (QCMP_BITS'(n_run) << QUANT_SHIFT) >= r_thresh;
    assign w_frac_clamp = (r_frac > QUANT_ONE) ? QUANT_ONE : r_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scale     <= SCALE_RESET;
            r_sum       <= '0;
            r_seen      <= '0;
            r_largest   <= '0;
            r_htot      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_frac <= i_item.quantile_fraction;
                        r_sel  <= i_item.bucket_select;
                        r_qb   <= '0;
                        r_bc   <= '0;
                        case (i_item.cmd)
                            CMD_SAMPLE:   r_state <= ST_MUL;
                            CMD_QUANTILE: r_state <= ST_QMUL;
                            CMD_READ:     r_state <= ST_RD;
                            CMD_CLEAR: begin
                                r_sum     <= '0;
                                r_seen    <= '0;
                                r_largest <= '0;
                                r_htot    <= '0;
                                r_valid   <= '0;
                                r_state   <= ST_DONE;
                            end
                            default:      r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_MUL: begin
                    r_state <= ST_ADDR;
                end
                ST_ADDR: begin
                    r_sum <= n_sum;
                    if (r_seen != '1) begin
                        r_seen <= r_seen + 1'b1;
                    end
                    if (w_calc.mag > r_largest) begin
                        r_largest <= w_calc.mag;
                    end
                    r_idx   <= w_calc.idx;
                    r_state <= ST_RMW;
                end
                ST_RMW: begin
                    r_valid[r_idx] <= 1'b1;
                    if (w_ram_we) begin
                        r_htot <= r_htot + 1'b1;
                    end
                    r_state <= ST_DONE;
                end
                ST_QMUL: begin
                    r_thresh <= QCMP_BITS'(r_htot) * QCMP_BITS'(w_frac_clamp);
                    r_run    <= '0;
                    r_qidx   <= '0;
                    r_state  <= ST_QCHK;
                end
                ST_QCHK: begin
                    r_run <= n_run;
                    if (w_hit || r_qidx == LAST_IDX) begin
                        r_qb    <= QB_BITS'(32'(r_qidx) + 1);
                        r_state <= ST_DONE;
                    end else begin
                        r_qidx <= r_qidx + 1'b1;
                    end
                end
                ST_RD: begin
                    r_state <= ST_RDCHK;
                end
                ST_RDCHK: begin
                    r_bc    <= w_sel_ok ? BC_BITS'(w_cnt) : '0;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_out_sum   <= r_sum;
                        r_out_seen  <= r_seen;
                        r_out_max   <= MAXERR_BITS'(r_largest);
                        r_out_qb    <= r_qb;
                        r_out_bc    <= r_bc;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.total_sq_error  = r_out_sum;
    assign o_result.sample_count    = r_out_seen;
    assign o_result.max_abs_error   = r_out_max;
    assign o_result.quantile_bucket = r_out_qb;
    assign o_result.bucket_count    = r_out_bc;
endmodule
